>>> rtl/power_rail_sequencer_defines.svh
// Assertion macros for the power rail sequencer.
// PRS_ASSERT is gated off while reset is asserted; PRS_ASSERT_ALWAYS is not.
`ifndef POWER_RAIL_SEQUENCER_DEFINES_SVH
`define POWER_RAIL_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

`define PRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PRS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PRS_ASSERT(label, clk, rst_n, prop, msg)

`define PRS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/prs_pkg.sv
package prs_pkg;

    // Overcurrent qualifier saturation point
    localparam logic [3:0] OVER_MAX = 4'd10;

    // Mode codes
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_BFAULT = 3'd1;
    localparam logic [2:0] MODE_AFAULT = 3'd2;
    localparam logic [2:0] MODE_OFF    = 3'd3;
    localparam logic [2:0] MODE_MFAULT = 3'd4;
    localparam logic [2:0] MODE_BON    = 3'd5;
    localparam logic [2:0] MODE_AON    = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] REG_BOARD_LIMIT = 2'd0;
    localparam logic [1:0] REG_MOTOR_LIMIT = 2'd1;
    localparam logic [1:0] REG_REARM_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [14:0] BOARD_LIMIT_RST = 15'd6000;
    localparam logic [14:0] MOTOR_LIMIT_RST = 15'd10000;
    localparam logic [15:0] REARM_TICKS_RST = 16'd20000;

    // Bit positions in fault, command and enable vectors
    localparam int FLT_BOARD  = 0;
    localparam int FLT_MOTOR  = 1;
    localparam int FLT_SWITCH = 2;
    localparam int CMD_BOARD   = 0;
    localparam int CMD_MOTOR   = 1;
    localparam int CMD_SWITCH  = 2;
    localparam int CMD_RESTART = 3;

    typedef struct packed {
        logic [14:0] board_current_limit;
        logic [14:0] motor_current_limit;
        logic [15:0] rearm_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] board_current_ma;
        logic signed [15:0] motor_current_ma;
        logic               switch_fault_event;
        logic               switch_power_good;
        logic               cmd_valid;
        logic [7:0]         cmd_byte;
    } sample_t;

    typedef struct packed {
        logic       board_enable;
        logic       motor_enable;
        logic       switch_enable;
        logic [2:0] mode;
        logic [7:0] status_byte;
    } result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] rearm_count;
        logic [3:0]  board_over_count;
        logic [3:0]  motor_over_count;
        logic [2:0]  fault_flags;
        logic [3:0]  command_bits;
        logic [2:0]  enable_regs;
    } state_t;

endpackage

>>> rtl/prs_ifs.sv
// Sample channel: one transaction per 1 ms tick
interface prs_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] board_current_ma;
    logic signed [15:0] motor_current_ma;
    logic               switch_fault_event;
    logic               switch_power_good;
    logic               cmd_valid;
    logic [7:0]         cmd_byte;

    modport source (
        output valid, board_current_ma, motor_current_ma, switch_fault_event,
               switch_power_good, cmd_valid, cmd_byte,
        input  ready
    );
    modport sink (
        input  valid, board_current_ma, motor_current_ma, switch_fault_event,
               switch_power_good, cmd_valid, cmd_byte,
        output ready
    );
endinterface

// Result channel: enables, mode and status per tick
interface prs_result_if;
    logic       valid;
    logic       ready;
    logic       board_enable;
    logic       motor_enable;
    logic       switch_enable;
    logic [2:0] mode;
    logic [7:0] status_byte;

    modport source (
        output valid, board_enable, motor_enable, switch_enable, mode, status_byte,
        input  ready
    );
    modport sink (
        input  valid, board_enable, motor_enable, switch_enable, mode, status_byte,
        output ready
    );
endinterface

>>> rtl/prs_step.sv
module prs_step (
    input  prs_pkg::cfg_t    cfg,
    input  prs_pkg::state_t  state,
    input  prs_pkg::sample_t sample,
    output prs_pkg::state_t  state_next,
    output prs_pkg::result_t result
);
    import prs_pkg::*;

    // Up/down qualifier; returns {fault_set, count_next}
    function automatic logic [4:0] qualify(
        input logic signed [15:0] cur,
        input logic [14:0]        limit,
        input logic [3:0]         cnt
    );
        logic       over;
        logic       flag;
        logic [3:0] cnt_n;
        over  = cur > $signed({1'b0, limit});
        flag  = 1'b0;
        cnt_n = cnt;
        if (over) begin
            if (cnt < OVER_MAX)
                cnt_n = cnt + 4'd1;
            else
                flag = 1'b1;
        end
        else if (cnt != 4'd0) begin
            cnt_n = cnt - 4'd1;
        end
        return {flag, cnt_n};
    endfunction

    logic [4:0]  board_q;
    logic [4:0]  motor_q;
    logic [2:0]  flt_q;
    logic [2:0]  mode_sel;
    logic [15:0] rearm_base;
    logic [15:0] rearm_next;
    logic [2:0]  flt_act;
    logic [3:0]  cmd_act;
    logic [2:0]  en_act;
    logic [3:0]  bcnt_act;
    logic [3:0]  mcnt_act;
    logic [3:0]  cmd_new;

    // Current qualification and fault latching
    always_comb
    begin
        board_q = qualify(sample.board_current_ma, cfg.board_current_limit,
                          state.board_over_count);
        motor_q = qualify(sample.motor_current_ma, cfg.motor_current_limit,
                          state.motor_over_count);
        flt_q   = state.fault_flags | {sample.switch_fault_event, motor_q[4], board_q[4]};
    end

    // Mode selection by priority
    always_comb
    begin
        priority if (state.command_bits[CMD_RESTART])
            mode_sel = MODE_START;
        else if (flt_q[FLT_BOARD])
            mode_sel = (!flt_q[FLT_MOTOR] && !flt_q[FLT_SWITCH]) ? MODE_BFAULT : MODE_AFAULT;
        else if (!state.command_bits[CMD_BOARD])
            mode_sel = MODE_OFF;
        else if (flt_q[FLT_MOTOR] || flt_q[FLT_SWITCH])
            mode_sel = MODE_MFAULT;
        else if (state.command_bits[CMD_MOTOR] && state.command_bits[CMD_SWITCH]
                 && (state.rearm_count >= cfg.rearm_ticks))
            mode_sel = MODE_AON;
        else
            mode_sel = MODE_BON;
    end

    // Rearm timer: cleared on leaving all-on, then counts up to the limit
    always_comb
    begin
        rearm_base = (state.mode == MODE_AON && mode_sel != MODE_AON) ? 16'd0
                                                                       : state.rearm_count;
        rearm_next = (rearm_base < cfg.rearm_ticks) ? rearm_base + 16'd1
                                                     : rearm_base;
    end

    // Mode actions
    always_comb
    begin
        flt_act  = flt_q;
        cmd_act  = state.command_bits;
        en_act   = state.enable_regs;
        bcnt_act = board_q[3:0];
        mcnt_act = motor_q[3:0];
        unique case (mode_sel)
            MODE_START:
                flt_act = 3'b000;
            MODE_OFF:
                en_act = 3'b000;
            MODE_BON:
                en_act = 3'b001;
            MODE_AON:
                en_act = 3'b111;
            MODE_BFAULT:
            begin
                en_act             = 3'b000;
                cmd_act            = cmd_act & 4'b1000;
                flt_act[FLT_BOARD] = 1'b1;
                bcnt_act           = 4'd0;
            end
            MODE_MFAULT:
            begin
                en_act             = 3'b001;
                cmd_act[CMD_MOTOR] = 1'b0;
                flt_act[FLT_MOTOR] = 1'b1;
                mcnt_act           = 4'd0;
            end
            default:
                ; // all fault holds everything
        endcase
    end

    // Command capture, effective from the next tick
    always_comb
    begin
        cmd_new = sample.cmd_valid
                ? {sample.cmd_byte[0], sample.cmd_byte[3], sample.cmd_byte[5], sample.cmd_byte[7]}
                : cmd_act;
    end

    always_comb
    begin
        state_next.mode             = mode_sel;
        state_next.rearm_count      = rearm_next;
        state_next.board_over_count = bcnt_act;
        state_next.motor_over_count = mcnt_act;
        state_next.fault_flags      = flt_act;
        state_next.command_bits     = cmd_new;
        state_next.enable_regs      = en_act;
    end

    // Result; status uses commands before this tick's command byte
    always_comb
    begin
        result.board_enable  = en_act[0];
        result.motor_enable  = en_act[1];
        result.switch_enable = en_act[2];
        result.mode          = mode_sel;
        result.status_byte   = {cmd_act[CMD_BOARD], flt_act[FLT_BOARD],
                                cmd_act[CMD_MOTOR], flt_act[FLT_MOTOR],
                                cmd_act[CMD_SWITCH], sample.switch_power_good,
                                flt_act[FLT_SWITCH], cmd_act[CMD_RESTART]};
    end

endmodule

>>> rtl/power_rail_sequencer.sv
// Channel   Direction  Contents
// sample    sink       board/motor current, switch fault, power good, command byte
// result    source     board/motor/switch enables, mode, status byte A
// cfg_*     write      current limits and rearm tick count
//
// A result passes through the input register, then the result register, so the
// result handshake completes only once both registers have been loaded; one
// sample per cycle sustained while the result side is not stalled.
// The state update for a tick happens in the cycle it moves into the result register.
// Reset: rst_n asynchronous, active low; state and limits return to defaults.
// Stalls: a held result blocks the input register only once both registers are full.
`include "power_rail_sequencer_defines.svh"

module power_rail_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    prs_sample_if.sink          sample,
    prs_result_if.source        result,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import prs_pkg::*;

    cfg_t    cfg_reg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    result_free;
    logic    advance;

    // Handshake control
    assign result_free  = !result_valid_reg || result.ready;
    assign advance      = sample_valid_reg && result_free;
    assign sample.ready = !sample_valid_reg || result_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.board_current_limit <= BOARD_LIMIT_RST;
            cfg_reg.motor_current_limit <= MOTOR_LIMIT_RST;
            cfg_reg.rearm_ticks         <= REARM_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BOARD_LIMIT: cfg_reg.board_current_limit <= cfg_data[14:0];
                REG_MOTOR_LIMIT: cfg_reg.motor_current_limit <= cfg_data[14:0];
                REG_REARM_TICKS: cfg_reg.rearm_ticks         <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (sample.ready)
            sample_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            sample_reg.board_current_ma   <= sample.board_current_ma;
            sample_reg.motor_current_ma   <= sample.motor_current_ma;
            sample_reg.switch_fault_event <= sample.switch_fault_event;
            sample_reg.switch_power_good  <= sample.switch_power_good;
            sample_reg.cmd_valid          <= sample.cmd_valid;
            sample_reg.cmd_byte           <= sample.cmd_byte;
        end
    end

    // Per-tick step logic
    prs_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (sample_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_free)
            result_valid_reg <= sample_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result.valid         = result_valid_reg;
    assign result.board_enable  = result_reg.board_enable;
    assign result.motor_enable  = result_reg.motor_enable;
    assign result.switch_enable = result_reg.switch_enable;
    assign result.mode          = result_reg.mode;
    assign result.status_byte   = result_reg.status_byte;

    // Checks
    `PRS_ASSERT(a_aon_all_enabled, clk, rst_n, (result_valid_reg && result_reg.mode == MODE_AON) |-> (result_reg.board_enable && result_reg.motor_enable && result_reg.switch_enable), "all-on result without all enables")
    `PRS_ASSERT(a_off_disabled, clk, rst_n, (result_valid_reg && (result_reg.mode == MODE_OFF || result_reg.mode == MODE_BFAULT)) |-> !(result_reg.board_enable || result_reg.motor_enable || result_reg.switch_enable), "off or board fault result with an enable set")
    `PRS_ASSERT(a_advance_gives_result, clk, rst_n, advance |=> result_valid_reg, "stepped tick produced no result")
    `PRS_ASSERT_ALWAYS(a_count_saturates, clk, (state_reg.board_over_count <= OVER_MAX) && (state_reg.motor_over_count <= OVER_MAX), "overcurrent counter past saturation")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import prs_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int LONG_HOLD    = 80;     // receiver back-pressure stretch
    localparam int DRAIN_CYCLES = 4;      // two-stage pipe plus margin
    localparam int AMP_MAX      = 20000;  // current magnitude range in mA

    // Enable patterns, bit0 board, bit1 motor, bit2 switch
    localparam logic [2:0] EN_NONE  = 3'b000;
    localparam logic [2:0] EN_BOARD = 3'b001;
    localparam logic [2:0] EN_ALL   = 3'b111;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    prs_sample_if sample_ch ();
    prs_result_if result_ch ();

    power_rail_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the limit registers
    logic [14:0] board_limit;
    logic [14:0] motor_limit;
    logic [15:0] rearm_limit;

    // Shadow sequencer state
    logic [2:0]  last_mode;
    logic [15:0] rearm_cnt;
    logic [3:0]  board_oc_cnt;
    logic [3:0]  motor_oc_cnt;
    logic [2:0]  faults;
    logic [3:0]  commands;
    logic [2:0]  enables;

    sample_t pending_ticks[$];
    result_t expected_outputs[$];

    int ticks_issued;
    int ticks_accepted;
    int err_count;
    int quiet_cycles;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_left;
    bit hold_request;
    bit tick_taken;
    int board_burst;
    int motor_burst;

    // Up/down overcurrent qualifier, latches the fault once saturated
    function automatic void qualify_current(input logic signed [15:0] amps,
                                            input logic [14:0] lim,
                                            inout logic [3:0] cnt,
                                            inout logic [2:0] flags,
                                            input int pos);
        if (amps > $signed({1'b0, lim}))
        begin
            if (cnt < OVER_MAX)
                cnt = cnt + 4'd1;
            else
                flags[pos] = 1'b1;
        end
        else if (cnt != 4'd0)
        begin
            cnt = cnt - 4'd1;
        end
    endfunction

    // One tick of the sequencer: returns enables, mode and status byte A
    function automatic result_t predict_tick(input sample_t s);
        result_t    r;
        logic [2:0] m;
        logic [7:0] c;
        qualify_current(s.board_current_ma, board_limit, board_oc_cnt, faults, FLT_BOARD);
        qualify_current(s.motor_current_ma, motor_limit, motor_oc_cnt, faults, FLT_MOTOR);
        if (s.switch_fault_event)
            faults[FLT_SWITCH] = 1'b1;

        // priority-ordered mode pick
        if (commands[CMD_RESTART])
            m = MODE_START;
        else if (faults[FLT_BOARD])
            m = (faults[FLT_MOTOR] || faults[FLT_SWITCH]) ? MODE_AFAULT : MODE_BFAULT;
        else if (!commands[CMD_BOARD])
            m = MODE_OFF;
        else if (faults[FLT_MOTOR] || faults[FLT_SWITCH])
            m = MODE_MFAULT;
        else if (commands[CMD_MOTOR] && commands[CMD_SWITCH] && rearm_cnt >= rearm_limit)
            m = MODE_AON;
        else
            m = MODE_BON;

        // rearm timer restarts on leaving all-on, then counts up to the limit
        if (last_mode == MODE_AON && m != MODE_AON)
            rearm_cnt = '0;
        if (rearm_cnt < rearm_limit)
            rearm_cnt = rearm_cnt + 16'd1;
        last_mode = m;

        case (m)
            MODE_START:
                faults = '0;
            MODE_OFF:
                enables = EN_NONE;
            MODE_BON:
                enables = EN_BOARD;
            MODE_AON:
                enables = EN_ALL;
            MODE_BFAULT:
            begin
                enables = EN_NONE;
                commands[CMD_BOARD]  = 1'b0;
                commands[CMD_MOTOR]  = 1'b0;
                commands[CMD_SWITCH] = 1'b0;
                faults[FLT_BOARD]    = 1'b1;
                board_oc_cnt         = '0;
            end
            MODE_MFAULT:
            begin
                enables = EN_BOARD;
                commands[CMD_MOTOR] = 1'b0;
                faults[FLT_MOTOR]   = 1'b1;
                motor_oc_cnt        = '0;
            end
            default:
                ;  // all-fault holds everything
        endcase

        // status reflects commands before this tick's byte is taken
        r.status_byte = {commands[CMD_BOARD], faults[FLT_BOARD],
                         commands[CMD_MOTOR], faults[FLT_MOTOR],
                         commands[CMD_SWITCH], s.switch_power_good,
                         faults[FLT_SWITCH], commands[CMD_RESTART]};
        if (s.cmd_valid)
        begin
            c = s.cmd_byte;
            commands[CMD_BOARD]   = c[7];
            commands[CMD_MOTOR]   = c[5];
            commands[CMD_SWITCH]  = c[3];
            commands[CMD_RESTART] = c[0];
        end
        r.board_enable  = enables[0];
        r.motor_enable  = enables[1];
        r.switch_enable = enables[2];
        r.mode          = m;
        return r;
    endfunction

    // Current draw: mostly under the limit, with overcurrent bursts of varied length
    function automatic logic signed [15:0] pick_current(input logic [14:0] lim,
                                                       inout int burst);
        int hi;
        int v;
        hi = (int'(lim) < AMP_MAX) ? int'(lim) : AMP_MAX;
        if (burst == 0 && $urandom_range(99) < 4)
            burst = $urandom_range(16, 4);
        if (burst > 0)
        begin
            burst--;
            v = (hi < AMP_MAX) ? hi + 1 + int'($urandom_range(AMP_MAX - hi - 1)) : hi;
        end
        else if ($urandom_range(99) < 10)
            v = int'($urandom_range(2 * AMP_MAX)) - AMP_MAX;
        else if ($urandom_range(99) < 70)
            v = int'($urandom_range(hi));
        else
            v = int'($urandom_range(hi + AMP_MAX)) - AMP_MAX;
        return v[15:0];
    endfunction

    function automatic sample_t random_tick();
        sample_t    s;
        logic [7:0] c;
        s.board_current_ma   = pick_current(board_limit, board_burst);
        s.motor_current_ma   = pick_current(motor_limit, motor_burst);
        s.switch_fault_event = ($urandom_range(99) < 2);
        s.switch_power_good  = 1'($urandom_range(1));
        s.cmd_valid          = ($urandom_range(99) < 12);
        if ($urandom_range(99) < 10)
        begin
            c = 8'($urandom_range(255));  // arbitrary byte
        end
        else
        begin
            c    = 8'($urandom_range(255)) & 8'h56;  // unused bits stay random
            c[7] = ($urandom_range(99) < 88);
            c[5] = ($urandom_range(99) < 75);
            c[3] = ($urandom_range(99) < 75);
            c[0] = ($urandom_range(99) < 10);
        end
        s.cmd_byte = c;
        return s;
    endfunction

    task automatic enqueue(input sample_t s);
        pending_ticks.push_back(s);
        ticks_issued++;
    endtask

    task automatic directed(input int b_ma, input int m_ma, input bit sw_flt,
                            input bit pgood, input bit cv, input logic [7:0] cb);
        sample_t s;
        s.board_current_ma   = b_ma[15:0];
        s.motor_current_ma   = m_ma[15:0];
        s.switch_fault_event = sw_flt;
        s.switch_power_good  = pgood;
        s.cmd_valid          = cv;
        s.cmd_byte           = cb;
        enqueue(s);
    endtask

    // Wait until every tick went in and every result came back
    task automatic wait_idle();
        @(negedge clk);
        while (ticks_accepted != ticks_issued || expected_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_BOARD_LIMIT: board_limit = value[14:0];
            REG_MOTOR_LIMIT: motor_limit = value[14:0];
            REG_REARM_TICKS: rearm_limit = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [14:0] b_lim, input logic [14:0] m_lim,
                             input logic [15:0] r_ticks, input int src_pct,
                             input int snk_pct, input int n_ticks, input bit long_hold);
        wait_idle();
        write_reg(REG_BOARD_LIMIT, {1'b0, b_lim});
        write_reg(REG_MOTOR_LIMIT, {1'b0, m_lim});
        write_reg(REG_REARM_TICKS, r_ticks);
        cfg_wr_en     <= 1'b0;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        hold_request  = long_hold;
        repeat (n_ticks)
            enqueue(random_tick());
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample driver: holds a transaction until taken, idles at random
    always @(negedge clk)
    begin
        sample_t next_tick;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else if (sample_ch.valid && !tick_taken)
        begin
            // still waiting for ready
        end
        else if (pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct)
        begin
            next_tick = pending_ticks.pop_front();
            sample_ch.board_current_ma   <= next_tick.board_current_ma;
            sample_ch.motor_current_ma   <= next_tick.motor_current_ma;
            sample_ch.switch_fault_event <= next_tick.switch_fault_event;
            sample_ch.switch_power_good  <= next_tick.switch_power_good;
            sample_ch.cmd_valid          <= next_tick.cmd_valid;
            sample_ch.cmd_byte           <= next_tick.cmd_byte;
            sample_ch.valid              <= 1'b1;
        end
        else
        begin
            sample_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold when requested
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitor: checks results, predicts on accepted ticks, watchdog
    always @(posedge clk)
    begin
        result_t want;
        sample_t got_tick;
        bit      moved;
        moved = 1'b0;
        tick_taken <= sample_ch.valid && sample_ch.ready;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            moved = 1'b1;
            if (expected_outputs.size() == 0)
            begin
                $error("result with no tick outstanding: mode %0d status 0x%02h",
                       result_ch.mode, result_ch.status_byte);
                err_count++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (result_ch.board_enable !== want.board_enable)
                begin
                    $error("board_enable: expected %0d, got %0d",
                           want.board_enable, result_ch.board_enable);
                    err_count++;
                end
                if (result_ch.motor_enable !== want.motor_enable)
                begin
                    $error("motor_enable: expected %0d, got %0d",
                           want.motor_enable, result_ch.motor_enable);
                    err_count++;
                end
                if (result_ch.switch_enable !== want.switch_enable)
                begin
                    $error("switch_enable: expected %0d, got %0d",
                           want.switch_enable, result_ch.switch_enable);
                    err_count++;
                end
                if (result_ch.mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, result_ch.mode);
                    err_count++;
                end
                if (result_ch.status_byte !== want.status_byte)
                begin
                    $error("status_byte: expected 0x%02h, got 0x%02h",
                           want.status_byte, result_ch.status_byte);
                    err_count++;
                end
            end
        end

        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            moved = 1'b1;
            got_tick.board_current_ma   = sample_ch.board_current_ma;
            got_tick.motor_current_ma   = sample_ch.motor_current_ma;
            got_tick.switch_fault_event = sample_ch.switch_fault_event;
            got_tick.switch_power_good  = sample_ch.switch_power_good;
            got_tick.cmd_valid          = sample_ch.cmd_valid;
            got_tick.cmd_byte           = sample_ch.cmd_byte;
            expected_outputs.push_back(predict_tick(got_tick));
            ticks_accepted++;
        end

        quiet_cycles = (!rst_n || moved) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BOARD_LIMIT;
        cfg_data  = '0;
        sample_ch.valid              = 1'b0;
        sample_ch.board_current_ma   = '0;
        sample_ch.motor_current_ma   = '0;
        sample_ch.switch_fault_event = 1'b0;
        sample_ch.switch_power_good  = 1'b0;
        sample_ch.cmd_valid          = 1'b0;
        sample_ch.cmd_byte           = '0;
        result_ch.ready              = 1'b0;

        board_limit  = BOARD_LIMIT_RST;
        motor_limit  = MOTOR_LIMIT_RST;
        rearm_limit  = REARM_TICKS_RST;
        last_mode    = MODE_START;
        rearm_cnt    = '0;
        board_oc_cnt = '0;
        motor_oc_cnt = '0;
        faults       = '0;
        commands     = '0;
        enables      = EN_NONE;

        ticks_issued   = 0;
        ticks_accepted = 0;
        err_count      = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_left      = 0;
        hold_request   = 1'b0;
        tick_taken     = 1'b0;
        board_burst    = 0;
        motor_burst    = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset limits: off, restart held, board on, switch fault,
        // board off, restart, board overcurrent qualifying to a board fault,
        // then a second fault giving all-fault
        directed(-20000, 20000, 1'b0, 1'b0, 1'b1, 8'hFF);
        directed(0, 0, 1'b0, 1'b1, 1'b1, 8'hA9);
        directed(0, 0, 1'b0, 1'b1, 1'b1, 8'hA8);
        directed(6000, 10000, 1'b0, 1'b0, 1'b0, 8'h00);
        directed(6000, 10001, 1'b1, 1'b1, 1'b0, 8'h00);
        directed(-1, -20000, 1'b0, 1'b0, 1'b1, 8'h00);
        directed(100, 100, 1'b0, 1'b1, 1'b1, 8'h81);
        directed(100, 100, 1'b0, 1'b0, 1'b1, 8'h80);
        for (int k = 0; k < 11; k++)
            directed((k % 2) ? 6001 : 20000, 0, 1'b0, k[0], 1'b0, 8'h00);
        directed(20000, 0, 1'b1, 1'b0, 1'b0, 8'h00);
        directed(6000, 0, 1'b0, 1'b1, 1'b0, 8'h00);

        // Directed, rearm limit zero: all-on allowed at once, then back to board on
        wait_idle();
        write_reg(REG_REARM_TICKS, 16'd0);
        cfg_wr_en <= 1'b0;
        directed(0, 0, 1'b0, 1'b0, 1'b1, 8'hA9);
        directed(0, 0, 1'b0, 1'b0, 1'b1, 8'hA8);
        directed(0, 0, 1'b0, 1'b1, 1'b0, 8'h00);
        directed(0, 0, 1'b0, 1'b1, 1'b1, 8'h80);
        directed(0, 0, 1'b0, 1'b0, 1'b0, 8'h00);

        // Random phases: limits, rearm count, sender idle %, receiver stall %
        run_phase(15'd3000, 15'd5000, 16'd8, 0, 0, 110, 1'b1);
        run_phase(15'd0, 15'd32767, 16'd40, 76, 0, 100, 1'b0);
        run_phase(15'd32767, 15'd0, 16'd300, 0, 76, 100, 1'b0);
        // rearm limit drops below the count left by the previous phase
        run_phase(15'd12000, 15'd9000, 16'd2, 15, 15, 100, 1'b0);
        run_phase(15'd6000, 15'd10000, 16'd65535, 0, 0, 80, 1'b0);
        run_phase(15'd20000, 15'd18000, 16'd0, 76, 0, 80, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
